### src/vfa_pkg.sv
// ----------------------------------------------------------------------------
// vfa_pkg
// Shared types and constants for the three-component fixed-point vector ALU.
// ----------------------------------------------------------------------------
package vfa_pkg;

	// Component format: two's complement, FRAC_BITS of them fraction bits
	localparam int COMP_WIDTH = 32;
	localparam int FRAC_BITS  = 16;

	typedef enum logic [2:0] {
		OP_ADD    = 3'd0,
		OP_SUB    = 3'd1,
		OP_SCALE  = 3'd2,
		OP_DOT    = 3'd3,
		OP_CROSS  = 3'd4,
		OP_LENGTH = 3'd5,
		OP_NORM   = 3'd6,
		OP_NEG    = 3'd7
	} op_t;

	typedef logic signed [COMP_WIDTH-1:0] comp_t;

	// Request payload
	typedef struct packed {
		logic [2:0] func;
		comp_t      ax;
		comp_t      ay;
		comp_t      az;
		comp_t      bx;
		comp_t      by;
		comp_t      bz;
		comp_t      scalar_in;
	} cmd_t;

	// Result payload
	typedef struct packed {
		comp_t rx;
		comp_t ry;
		comp_t rz;
		comp_t scalar_out;
		logic  overflow;
	} rsp_t;

endpackage

### src/vector3_fixed_point_alu.sv
// ----------------------------------------------------------------------------
// vector3_fixed_point_alu
// Fully pipelined vector unit: add, sub, scale, dot, cross, length, normalize,
// negate on signed fixed-point three-component vectors, with saturation.
// ----------------------------------------------------------------------------
// The unit takes one request per clock while cmd_stall is low and sends every
// operation down the same pipeline (default format Q16.16). The pipeline length
// is set by the square root, which resolves one root bit per stage (COMP_WIDTH
// stages), and the reciprocal for normalize, which resolves one quotient bit
// per stage (2*FRAC_BITS+1 stages). The whole pipeline advances together; it
// holds only while a finished result is stalled at the output, and then
// cmd_stall is high.
module vector3_fixed_point_alu
	import vfa_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_stall,
	input  cmd_t cmd,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam int W    = COMP_WIDTH;
	localparam int F    = FRAC_BITS;
	localparam int XW   = 2 * W + 4;     // exact width of sums of products
	localparam int QW   = 2 * F + 1;     // reciprocal width
	localparam int RW   = W + 2;         // square root partial remainder
	localparam int SQ_N = W;             // root bits, one per stage
	localparam int DV_N = QW;            // quotient bits, one per stage

	typedef logic signed [XW-1:0] wide_t;

	typedef struct packed {
		op_t                   func;
		logic [2:0][W-1:0]     a;
		logic [3:0][XW-1:0]    pre;      // rx, ry, rz, scalar before saturation
	} carry_t;

	// Saturate to W bits; top bit of the result is the overflow flag
	function automatic logic [W:0] sat(input wide_t v);
		logic [W:0] r;
		if (v[XW-1:W-1] == {(XW-W+1){1'b0}} || v[XW-1:W-1] == {(XW-W+1){1'b1}}) begin
			r = {1'b0, v[W-1:0]};
		end else if (v[XW-1]) begin
			r = {1'b1, 1'b1, {(W-1){1'b0}}};
		end else begin
			r = {1'b1, 1'b0, {(W-1){1'b1}}};
		end
		return r;
	endfunction

	logic en;

	// Global advance: hold only when the output result is stalled
	assign en        = !(rsp_valid && rsp_stall);
	assign cmd_stall = !en;

	// ---------------------------------------------------------------- stage 1
	logic  vld_s1;
	op_t   func_s1;
	comp_t a_s1 [3];
	comp_t b_s1 [3];
	comp_t k_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			func_s1 <= op_t'(cmd.func);
			a_s1[0] <= cmd.ax;
			a_s1[1] <= cmd.ay;
			a_s1[2] <= cmd.az;
			b_s1[0] <= cmd.bx;
			b_s1[1] <= cmd.by;
			b_s1[2] <= cmd.bz;
			k_s1    <= cmd.scalar_in;
		end
	end

	// ---------------------------------------------------------------- stage 2
	// Operand selection for the six multipliers
	comp_t ma [6];
	comp_t mb [6];

	always_comb begin
		for (int k = 0; k < 6; k++) begin
			ma[k] = '0;
			mb[k] = '0;
		end
		case (func_s1) inside
			OP_SCALE: begin
				for (int i = 0; i < 3; i++) begin
					ma[i] = a_s1[i];
					mb[i] = k_s1;
				end
			end
			OP_DOT: begin
				for (int i = 0; i < 3; i++) begin
					ma[i] = a_s1[i];
					mb[i] = b_s1[i];
				end
			end
			OP_LENGTH, OP_NORM: begin
				for (int i = 0; i < 3; i++) begin
					ma[i] = a_s1[i];
					mb[i] = a_s1[i];
				end
			end
			OP_CROSS: begin
				ma[0] = a_s1[1]; mb[0] = b_s1[2];
				ma[1] = a_s1[2]; mb[1] = b_s1[1];
				ma[2] = a_s1[2]; mb[2] = b_s1[0];
				ma[3] = a_s1[0]; mb[3] = b_s1[2];
				ma[4] = a_s1[0]; mb[4] = b_s1[1];
				ma[5] = a_s1[1]; mb[5] = b_s1[0];
			end
			default: ;
		endcase
	end

	logic                  vld_s2;
	op_t                   func_s2;
	comp_t                 a_s2 [3];
	comp_t                 b_s2 [3];
	logic signed [2*W-1:0] p_s2 [6];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			func_s2 <= func_s1;
			for (int i = 0; i < 3; i++) begin
				a_s2[i] <= a_s1[i];
				b_s2[i] <= b_s1[i];
			end
			for (int k = 0; k < 6; k++) begin
				p_s2[k] <= ma[k] * mb[k];
			end
		end
	end

	// ---------------------------------------------------------------- stage 3
	// Exact sums, fraction shift, radicand for the square root
	wide_t       pw [6];
	wide_t       aw [3];
	wide_t       bw [3];
	wide_t       dsum;
	logic [3:0][XW-1:0] pre_c;

	always_comb begin
		for (int k = 0; k < 6; k++) begin
			pw[k] = wide_t'(p_s2[k]);
		end
		for (int i = 0; i < 3; i++) begin
			aw[i] = wide_t'(a_s2[i]);
			bw[i] = wide_t'(b_s2[i]);
		end
		dsum  = pw[0] + pw[1] + pw[2];
		pre_c = '0;
		case (func_s2)
			OP_ADD: begin
				for (int i = 0; i < 3; i++) pre_c[i] = aw[i] + bw[i];
			end
			OP_SUB: begin
				for (int i = 0; i < 3; i++) pre_c[i] = aw[i] - bw[i];
			end
			OP_NEG: begin
				for (int i = 0; i < 3; i++) pre_c[i] = -aw[i];
			end
			OP_SCALE: begin
				for (int i = 0; i < 3; i++) pre_c[i] = pw[i] >>> F;
			end
			OP_DOT: begin
				pre_c[3] = dsum >>> F;
			end
			OP_CROSS: begin
				pre_c[0] = (pw[0] - pw[1]) >>> F;
				pre_c[1] = (pw[2] - pw[3]) >>> F;
				pre_c[2] = (pw[4] - pw[5]) >>> F;
			end
			default: ;
		endcase
	end

	// Square root pipeline, entry 0 is the stage 3 register
	logic           sq_v    [SQ_N+1];
	carry_t         sq_c    [SQ_N+1];
	logic [2*W-1:0] sq_rad  [SQ_N+1];
	logic [RW-1:0]  sq_rem  [SQ_N+1];
	logic [W-1:0]   sq_root [SQ_N+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_v[0] <= 1'b0;
		end else if (en) begin
			sq_v[0] <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_c[0].func <= func_s2;
			for (int i = 0; i < 3; i++) sq_c[0].a[i] <= a_s2[i];
			sq_c[0].pre  <= pre_c;
			sq_rad[0]    <= dsum[2*W-1:0];
			sq_rem[0]    <= '0;
			sq_root[0]   <= '0;
		end
	end

	// ------------------------------------------------------ square root stages
	// One root bit per stage, digit-by-digit on bit pairs of the radicand
	for (genvar k = 0; k < SQ_N; k++) begin : g_sqrt
		logic [RW-1:0] rn;
		logic [RW-1:0] t;

		assign rn = {sq_rem[k][RW-3:0], sq_rad[k][2*W-1 -: 2]};
		assign t  = {sq_root[k], 2'b01};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_v[k+1] <= 1'b0;
			end else if (en) begin
				sq_v[k+1] <= sq_v[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sq_c[k+1]   <= sq_c[k];
				sq_rad[k+1] <= {sq_rad[k][2*W-3:0], 2'b00};
				if (rn >= t) begin
					sq_rem[k+1]  <= rn - t;
					sq_root[k+1] <= {sq_root[k][W-2:0], 1'b1};
				end else begin
					sq_rem[k+1]  <= rn;
					sq_root[k+1] <= {sq_root[k][W-2:0], 1'b0};
				end
			end
		end
	end

	// ------------------------------------------------------- reciprocal stages
	// floor(2^(2F) / root), one quotient bit per stage, restoring division
	logic          dv_v   [DV_N];
	carry_t        dv_c   [DV_N];
	logic [W-1:0]  dv_d   [DV_N];
	logic [W-1:0]  dv_rem [DV_N];
	logic [QW-1:0] dv_q   [DV_N];

	for (genvar j = 0; j < DV_N; j++) begin : g_div
		logic          vi;
		carry_t        ci;
		logic [W-1:0]  di;
		logic [W-1:0]  remi;
		logic [QW-1:0] qi;
		logic          nb;
		logic [W:0]    rn;

		if (j == 0) begin : g_first
			assign vi   = sq_v[SQ_N];
			assign ci   = sq_c[SQ_N];
			assign di   = sq_root[SQ_N];
			assign remi = '0;
			assign qi   = '0;
			assign nb   = 1'b1;          // dividend is a single one bit
		end else begin : g_next
			assign vi   = dv_v[j-1];
			assign ci   = dv_c[j-1];
			assign di   = dv_d[j-1];
			assign remi = dv_rem[j-1];
			assign qi   = dv_q[j-1];
			assign nb   = 1'b0;
		end

		assign rn = {remi, nb};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v[j] <= 1'b0;
			end else if (en) begin
				dv_v[j] <= vi;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_c[j] <= ci;
				dv_d[j] <= di;
				if (rn >= {1'b0, di}) begin
					dv_rem[j] <= rn[W-1:0] - di;
					dv_q[j]   <= {qi[QW-2:0], 1'b1};
				end else begin
					dv_rem[j] <= rn[W-1:0];
					dv_q[j]   <= {qi[QW-2:0], 1'b0};
				end
			end
		end
	end

	// ------------------------------------------------------- multiply stage
	// Normalize scaling by the reciprocal, length result insert
	carry_t                 cm;
	logic [W-1:0]           dm;
	logic [QW-1:0]          qm;
	logic signed [W+QW:0]   prod [3];
	logic [3:0][XW-1:0]     pre_m;

	assign cm = dv_c[DV_N-1];
	assign dm = dv_d[DV_N-1];
	assign qm = dv_q[DV_N-1];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			prod[i] = $signed(cm.a[i]) * $signed({1'b0, qm});
		end
		pre_m = cm.pre;
		case (cm.func)
			OP_NORM: begin
				for (int i = 0; i < 3; i++) begin
					if (dm != '0) begin
						pre_m[i] = wide_t'(prod[i] >>> F);
					end else begin
						pre_m[i] = wide_t'($signed(cm.a[i]));
					end
				end
				pre_m[3] = '0;
			end
			OP_LENGTH: begin
				pre_m[3] = XW'(dm);
			end
			default: ;
		endcase
	end

	logic               vld_sm;
	op_t                func_sm;
	logic [3:0][XW-1:0] pre_sm;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sm <= 1'b0;
		end else if (en) begin
			vld_sm <= dv_v[DV_N-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			func_sm <= cm.func;
			pre_sm  <= pre_m;
		end
	end

	// ------------------------------------------------------- output stage
	logic [W:0] sv [4];

	always_comb begin
		for (int i = 0; i < 4; i++) sv[i] = sat(wide_t'(pre_sm[i]));
	end

	logic vld_so;
	op_t  func_so;
	rsp_t rsp_so;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_so <= 1'b0;
		end else if (en) begin
			vld_so <= vld_sm;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			func_so           <= func_sm;
			rsp_so.rx         <= sv[0][W-1:0];
			rsp_so.ry         <= sv[1][W-1:0];
			rsp_so.rz         <= sv[2][W-1:0];
			rsp_so.scalar_out <= sv[3][W-1:0];
			rsp_so.overflow   <= sv[0][W] | sv[1][W] | sv[2][W] | sv[3][W];
		end
	end

	assign rsp_valid = vld_so;
	assign rsp       = rsp_so;

	// ------------------------------------------------------- assertions
	// Length and dot leave the vector fields at zero
	a_scalar_ops_no_vec: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (func_so == OP_LENGTH || func_so == OP_DOT)
			|-> rsp.rx == '0 && rsp.ry == '0 && rsp.rz == '0)
		else $error("vector field set on a scalar operation");

	// Only length and dot produce a scalar
	a_vec_ops_no_scalar: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && func_so != OP_LENGTH && func_so != OP_DOT
			|-> rsp.scalar_out == '0)
		else $error("scalar field set on a vector operation");

	// A unit vector never saturates
	a_norm_no_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && func_so == OP_NORM |-> !rsp.overflow)
		else $error("normalize result saturated");

	// Length is never negative
	a_len_positive: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && func_so == OP_LENGTH |-> !rsp.scalar_out[W-1])
		else $error("negative length");

endmodule

### test/vector3_fixed_point_alu_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector3_fixed_point_alu_checker
// Watches both channels of the vector ALU, computes the expected result of
// every accepted request and compares each accepted result field by field.
// ----------------------------------------------------------------------------
module vector3_fixed_point_alu_checker
	import vfa_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	input  logic cmd_stall,
	input  cmd_t cmd,
	input  logic rsp_valid,
	input  logic rsp_stall,
	input  rsp_t rsp,
	output int   mismatches,
	output int   pending
);

	localparam logic signed [127:0] CMAX_W = (128'sd1 <<< (COMP_WIDTH - 1)) - 1;
	localparam logic signed [127:0] CMIN_W = -CMAX_W - 1;

	rsp_t expected_rsp_q[$];

	// Clamp an exact value to the component range
	function automatic comp_t clamp(input logic signed [127:0] v, inout logic ovf);
		if (v > CMAX_W) begin
			ovf = 1'b1;
			return CMAX_W[COMP_WIDTH-1:0];
		end
		if (v < CMIN_W) begin
			ovf = 1'b1;
			return CMIN_W[COMP_WIDTH-1:0];
		end
		return v[COMP_WIDTH-1:0];
	endfunction

	// Floor square root of a non-negative exact value
	function automatic logic [63:0] floor_sqrt(input logic [127:0] s);
		logic [63:0] root;
		logic [63:0] trial;
		root = '0;
		for (int bit_i = 63; bit_i >= 0; bit_i--) begin
			trial = root | (64'd1 << bit_i);
			if ({64'd0, trial} * {64'd0, trial} <= s)
				root = trial;
		end
		return root;
	endfunction

	function automatic rsp_t vector_result(input cmd_t c);
		rsp_t r;
		logic signed [127:0] a[3], b[3], s, acc;
		logic [127:0] sum_sq;
		logic [63:0] len;
		logic signed [127:0] recip;
		logic ovf;
		a[0] = c.ax; a[1] = c.ay; a[2] = c.az;
		b[0] = c.bx; b[1] = c.by; b[2] = c.bz;
		s = c.scalar_in;
		r = '0;
		ovf = 1'b0;
		sum_sq = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
		case (op_t'(c.func))
			OP_ADD: begin
				r.rx = clamp(a[0] + b[0], ovf);
				r.ry = clamp(a[1] + b[1], ovf);
				r.rz = clamp(a[2] + b[2], ovf);
			end
			OP_SUB: begin
				r.rx = clamp(a[0] - b[0], ovf);
				r.ry = clamp(a[1] - b[1], ovf);
				r.rz = clamp(a[2] - b[2], ovf);
			end
			OP_SCALE: begin
				r.rx = clamp((a[0] * s) >>> FRAC_BITS, ovf);
				r.ry = clamp((a[1] * s) >>> FRAC_BITS, ovf);
				r.rz = clamp((a[2] * s) >>> FRAC_BITS, ovf);
			end
			OP_DOT: begin
				acc = a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
				r.scalar_out = clamp(acc >>> FRAC_BITS, ovf);
			end
			OP_CROSS: begin
				r.rx = clamp((a[1] * b[2] - a[2] * b[1]) >>> FRAC_BITS, ovf);
				r.ry = clamp((a[2] * b[0] - a[0] * b[2]) >>> FRAC_BITS, ovf);
				r.rz = clamp((a[0] * b[1] - a[1] * b[0]) >>> FRAC_BITS, ovf);
			end
			OP_LENGTH: begin
				len = floor_sqrt(sum_sq);
				r.scalar_out = clamp($signed({64'd0, len}), ovf);
			end
			OP_NORM: begin
				len = floor_sqrt(sum_sq);
				if (len != 0) begin
					recip = $signed((128'd1 << (2 * FRAC_BITS)) / {64'd0, len});
					r.rx = clamp((a[0] * recip) >>> FRAC_BITS, ovf);
					r.ry = clamp((a[1] * recip) >>> FRAC_BITS, ovf);
					r.rz = clamp((a[2] * recip) >>> FRAC_BITS, ovf);
				end else begin
					r.rx = c.ax; r.ry = c.ay; r.rz = c.az;
				end
			end
			default: begin
				r.rx = clamp(-a[0], ovf);
				r.ry = clamp(-a[1], ovf);
				r.rz = clamp(-a[2], ovf);
			end
		endcase
		r.overflow = ovf;
		return r;
	endfunction

	assign pending = expected_rsp_q.size();

	// Predict on request, compare on result
	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			mismatches <= 0;
		end else begin
			if (cmd_valid && !cmd_stall)
				expected_rsp_q.push_back(vector_result(cmd));
			if (rsp_valid && !rsp_stall) begin
				if (expected_rsp_q.size() == 0) begin
					mismatches <= mismatches + 1;
					if (mismatches < 10)
						$display("%0t: unexpected result %h", $realtime, rsp);
				end else begin
					want = expected_rsp_q.pop_front();
					if (want !== rsp) begin
						mismatches <= mismatches + 1;
						if (mismatches < 10)
							$display("%0t: mismatch exp rx %h ry %h rz %h sc %h ov %b, got rx %h ry %h rz %h sc %h ov %b",
								$realtime, want.rx, want.ry, want.rz, want.scalar_out,
								want.overflow, rsp.rx, rsp.ry, rsp.rz, rsp.scalar_out,
								rsp.overflow);
					end
				end
			end
		end
	end

endmodule

### test/vector3_fixed_point_alu_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector3_fixed_point_alu_test
// Drives directed and random vector requests with random gaps and result
// stalls; the checker beside the unit predicts and compares every result.
// ----------------------------------------------------------------------------
module vector3_fixed_point_alu_test;
	import vfa_pkg::*;

	localparam int RANDOM_REQUESTS = 600;
	localparam int IDLE_LIMIT      = 2000;
	localparam int DRAIN_CYCLES    = 100;

	logic clk;
	logic arst_n;
	logic cmd_valid;
	logic cmd_stall;
	cmd_t cmd;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp;
	int   mismatches;
	int   pending;
	int   idle_cycles;

	vector3_fixed_point_alu dut (.*);

	vector3_fixed_point_alu_checker checker_i (.*);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Component patterns biased toward extremes and small magnitudes
	function automatic comp_t pick_comp();
		case ($urandom_range(0, 7))
			0: return comp_t'(32'h7FFF_FFFF);
			1: return comp_t'(32'h8000_0000);
			2: return comp_t'($signed($urandom_range(0, 8'hFF)) - 128);
			3: return comp_t'($urandom_range(0, 32'h0003_FFFF)) - comp_t'(32'h0002_0000);
			4: return '0;
			default: return comp_t'($urandom());
		endcase
	endfunction

	// Valid stays high across back-to-back requests; dropped only for a gap
	task automatic send_request(input cmd_t c);
		int gap;
		gap = $urandom_range(0, 19);
		if (gap != 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd       <= c;
		cmd_valid <= 1'b1;
		@(posedge clk);
		while (cmd_stall) @(posedge clk);
	endtask

	function automatic cmd_t make_request(input op_t op, input comp_t a0, a1, a2,
		input comp_t b0, b1, b2, input comp_t s);
		cmd_t c;
		c.func = op;
		c.ax = a0; c.ay = a1; c.az = a2;
		c.bx = b0; c.by = b1; c.bz = b2;
		c.scalar_in = s;
		return c;
	endfunction

	// Result side: stall for a drawn number of cycles per result
	initial begin
		int wait_n;
		rsp_stall = 1'b1;
		@(posedge arst_n);
		forever begin
			wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
			if (wait_n != 0) begin
				rsp_stall <= 1'b1;
				repeat (wait_n) @(posedge clk);
			end
			rsp_stall <= 1'b0;
			@(posedge clk);
			while (!rsp_valid) @(posedge clk);
		end
	end

	// Watchdog on cycles with no accepted request or result
	always @(posedge clk) begin
		if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		comp_t pmax, pmin, one;
		cmd_t c;
		pmax = comp_t'(32'h7FFF_FFFF);
		pmin = comp_t'(32'h8000_0000);
		one  = comp_t'(32'h0001_0000);
		arst_n      = 1'b0;
		cmd_valid   = 1'b0;
		cmd         = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: every operation, saturation, zero normalize, negate of minimum
		send_request(make_request(OP_ADD, pmax, pmin, one, one, pmin, 0, 0));
		send_request(make_request(OP_SUB, pmin, pmax, one, one, pmin, one, 0));
		send_request(make_request(OP_SCALE, pmax, pmin, one, 0, 0, 0, pmax));
		send_request(make_request(OP_SCALE, one, -one, 3 * one, 0, 0, 0, -one));
		send_request(make_request(OP_DOT, pmax, pmax, pmax, pmax, pmax, pmax, 0));
		send_request(make_request(OP_DOT, one, 2 * one, 0, 3 * one, -one, 0, 0));
		send_request(make_request(OP_CROSS, one, 0, 0, 0, one, 0, 0));
		send_request(make_request(OP_CROSS, pmax, pmin, pmax, pmin, pmax, pmin, 0));
		send_request(make_request(OP_LENGTH, 3 * one, 4 * one, 0, 0, 0, 0, 0));
		send_request(make_request(OP_LENGTH, pmin, pmin, pmin, 0, 0, 0, 0));
		send_request(make_request(OP_NORM, 0, 0, 0, pmax, pmin, one, pmin));
		send_request(make_request(OP_NORM, 3 * one, 0, -4 * one, 0, 0, 0, 0));
		send_request(make_request(OP_NORM, 1, 0, 0, 0, 0, 0, 0));
		send_request(make_request(OP_NORM, pmin, pmax, pmin, 0, 0, 0, 0));
		send_request(make_request(OP_NEG, pmin, pmax, 0, 0, 0, 0, 0));
		send_request(make_request(OP_NEG, -1, one, 1, 0, 0, 0, 0));

		// Random requests, some of them two-component
		for (int n = 0; n < RANDOM_REQUESTS; n++) begin
			c.func = 3'($urandom_range(0, 7));
			c.ax = pick_comp(); c.ay = pick_comp(); c.az = pick_comp();
			c.bx = pick_comp(); c.by = pick_comp(); c.bz = pick_comp();
			c.scalar_in = pick_comp();
			if ($urandom_range(0, 4) == 0) begin
				c.az = '0;
				c.bz = '0;
			end
			send_request(c);
		end
		cmd_valid <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

### vector3_fixed_point_alu.f
src/vfa_pkg.sv
src/vector3_fixed_point_alu.sv
test/vector3_fixed_point_alu_checker.sv
test/vector3_fixed_point_alu_test.sv
